// ----- rtl/dlcg_pkg.sv -----
`timescale 1ns / 1ps

package dlcg_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned IndexWidth = 3;

    localparam logic                 RstCombinedMode = 1'b1;
    localparam logic [WordWidth-1:0] RstMultMain     = 32'd1664525;
    localparam logic [WordWidth-1:0] RstIncrMain     = 32'd1013904223;
    localparam logic [WordWidth-1:0] RstMultSecond   = 32'd69069;
    localparam logic [WordWidth-1:0] RstIncrSecond   = 32'd3;
    localparam logic [WordWidth-1:0] RstSeedMain     = 32'd0;
    localparam logic [WordWidth-1:0] RstSeedSecond   = 32'd0;
    localparam logic [WordWidth-1:0] RstSeedSkip     = 32'd0;

    typedef enum logic [IndexWidth-1:0] {
        CFG_COMBINED_MODE = 3'd0,
        CFG_MULT_MAIN     = 3'd1,
        CFG_INCR_MAIN     = 3'd2,
        CFG_MULT_SECOND   = 3'd3,
        CFG_INCR_SECOND   = 3'd4,
        CFG_SEED_MAIN     = 3'd5,
        CFG_SEED_SECOND   = 3'd6,
        CFG_SEED_SKIP     = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAIN,
        ST_SECOND,
        ST_COMBINE
    } state_t;

    typedef struct packed {
        logic main_en;
        logic second_en;
        logic combine_en;
        logic imag;
        logic last;
    } step_t;

endpackage

// ----- rtl/dlcg_mac.sv -----
`timescale 1ns / 1ps

module dlcg_mac
    import dlcg_pkg::*;
(
    input  logic [WordWidth-1:0] x,
    input  logic [WordWidth-1:0] mult,
    input  logic [WordWidth-1:0] incr,
    output logic [WordWidth-1:0] result
);

    // The product is kept modulo 2^32, so only its low word is formed.
    assign result = x * mult + incr;

endmodule

// ----- rtl/dlcg_ctrl.sv -----
`timescale 1ns / 1ps

module dlcg_ctrl
    import dlcg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  logic  combined,
    input  logic  out_free,
    output logic  idle,
    output step_t step
);

    state_t state_reg, state_next;
    logic   imag_reg, imag_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            imag_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            imag_reg  <= imag_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        imag_next       = imag_reg;
        idle            = 1'b0;
        step            = '0;
        step.imag       = imag_reg;
        case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    state_next = ST_MAIN;
                    imag_next  = 1'b0;
                end
            end
            ST_MAIN: begin
                if (combined) begin
                    step.main_en = 1'b1;
                    state_next   = ST_SECOND;
                end else if (!imag_reg) begin
                    step.main_en = 1'b1;
                    imag_next    = 1'b1;
                end else if (out_free) begin
                    step.main_en = 1'b1;
                    step.last    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SECOND: begin
                step.second_en = 1'b1;
                state_next     = ST_COMBINE;
            end
            ST_COMBINE: begin
                if (!imag_reg) begin
                    step.combine_en = 1'b1;
                    imag_next       = 1'b1;
                    state_next      = ST_MAIN;
                end else if (out_free) begin
                    step.combine_en = 1'b1;
                    step.last       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dual_lcg_complex_uniform.sv -----
`timescale 1ns / 1ps

// Complex uniform sample generator built on linear congruential generators.
// The input stream carries requests: s_tdata bit 0 set asks for one sample,
// a word with that bit clear is taken and produces nothing. Each sample
// leaves on the output stream as two 32-bit fractions of 2^-32.
// One multiply-add unit serves every main and second step, one step per
// cycle unless a final step waits for the output. A request is two main
// steps in single mode, and main step, second step and combine, twice, in
// combined mode. The result is valid the cycle after the last step, and
// the block takes the next request in that same cycle. The output register
// lets work on the next request go on while a sample waits; only the final
// step of that request holds until the receiver takes the waiting word.
// Reset loads the documented register defaults and the seeds into the
// generator states. Configuration is written through cfg_wr_en, cfg_index
// and cfg_data, which the user must do only while no request is in flight
// (not checked by the block); a seed write also loads the matching generator state.
module dual_lcg_complex_uniform
    import dlcg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] request, [7:1] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*WordWidth-1:0] m_tdata,   // [31:0] real_frac, [63:32] imag_frac
    input  logic                   cfg_wr_en,
    input  logic [IndexWidth-1:0]  cfg_index,
    input  logic [WordWidth-1:0]   cfg_data
);

    logic                 combined_mode_reg;
    logic [WordWidth-1:0] mult_main_reg, incr_main_reg;
    logic [WordWidth-1:0] mult_second_reg, incr_second_reg;
    logic [WordWidth-1:0] main_state_reg, main_state_next;
    logic [WordWidth-1:0] second_state_reg, second_state_next;
    logic [WordWidth-1:0] skip_marker_reg, skip_marker_next;
    logic [WordWidth-1:0] real_reg, real_next;
    logic [2*WordWidth-1:0] out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 idle;
    logic                 out_free;
    step_t                step;
    logic [WordWidth-1:0] mac_x, mac_mult, mac_incr, mac_result;
    logic [WordWidth-1:0] diff;
    logic [WordWidth-1:0] sample;

    assign out_free = !out_valid_reg || m_tready;

    dlcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && s_tdata[0]),
        .combined (combined_mode_reg),
        .out_free (out_free),
        .idle     (idle),
        .step     (step)
    );

    assign mac_x    = step.second_en ? second_state_reg : main_state_reg;
    assign mac_mult = step.second_en ? mult_second_reg  : mult_main_reg;
    assign mac_incr = step.second_en ? incr_second_reg  : incr_main_reg;

    dlcg_mac u_mac (
        .x      (mac_x),
        .mult   (mac_mult),
        .incr   (mac_incr),
        .result (mac_result)
    );

    assign diff   = main_state_reg - second_state_reg;
    assign sample = step.combine_en ? {diff[WordWidth-1:9], 1'b1, 8'h00} : mac_result;

    always_comb begin
        main_state_next   = main_state_reg;
        second_state_next = second_state_reg;
        skip_marker_next  = skip_marker_reg;
        real_next         = real_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !m_tready;

        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SEED_MAIN:   main_state_next   = cfg_data;
                CFG_SEED_SECOND: second_state_next = cfg_data;
                CFG_SEED_SKIP:   skip_marker_next  = cfg_data;
                default: begin
                end
            endcase
        end

        if (step.main_en) begin
            main_state_next = mac_result;
        end
        if (step.second_en) begin
            second_state_next = mac_result;
        end
        if (step.combine_en && (second_state_reg == skip_marker_reg)) begin
            second_state_next = second_state_reg + WordWidth'(1);
            skip_marker_next  = skip_marker_reg + WordWidth'(1);
        end

        if ((step.main_en && !combined_mode_reg) || step.combine_en) begin
            if (step.imag) begin
                out_next       = {sample, real_reg};
                out_valid_next = 1'b1;
            end else begin
                real_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            combined_mode_reg <= RstCombinedMode;
            mult_main_reg     <= RstMultMain;
            incr_main_reg     <= RstIncrMain;
            mult_second_reg   <= RstMultSecond;
            incr_second_reg   <= RstIncrSecond;
            main_state_reg    <= RstSeedMain;
            second_state_reg  <= RstSeedSecond;
            skip_marker_reg   <= RstSeedSkip;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    CFG_COMBINED_MODE: combined_mode_reg <= cfg_data[0];
                    CFG_MULT_MAIN:     mult_main_reg     <= cfg_data;
                    CFG_INCR_MAIN:     incr_main_reg     <= cfg_data;
                    CFG_MULT_SECOND:   mult_second_reg   <= cfg_data;
                    CFG_INCR_SECOND:   incr_second_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            main_state_reg   <= main_state_next;
            second_state_reg <= second_state_next;
            skip_marker_reg  <= skip_marker_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        real_reg <= real_next;
        out_reg  <= out_next;
    end

    assign s_tready = idle;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({step.main_en, step.second_en, step.combine_en}))
        else $error("more than one generator step in a cycle");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(step.main_en || step.second_en || step.combine_en))
        else $error("request taken while a step is active");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        step.last |-> (!out_valid_reg || m_tready))
        else $error("final step overwrote a waiting sample");

    a_combined_low_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) && combined_mode_reg |->
            (out_reg[8:0] == 9'h100) && (out_reg[40:32] == 9'h100))
        else $error("combined sample lacks its fixed low bits");

endmodule
